@@ rtl/core/rri_pkg.sv @@
package rri_pkg;

  localparam int CORNER_W   = 48;
  localparam int LIMIT_W    = 47;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_CORNER_A       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_B       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_D       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PARALLEL_LIMIT = 2'd3;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_BEHIND   = 2'd2,
    ST_OUTSIDE  = 2'd3
  } rri_status_t;

endpackage

@@ rtl/core/rri_if.sv @@
interface rri_in_if #(parameter int CW = 16) ();
  logic          valid;
  logic          ready;
  logic signed [CW-1:0] origin_x;
  logic signed [CW-1:0] origin_y;
  logic signed [CW-1:0] origin_z;
  logic signed [CW-1:0] target_x;
  logic signed [CW-1:0] target_y;
  logic signed [CW-1:0] target_z;

  modport source (output valid, origin_x, origin_y, origin_z, target_x, target_y, target_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, target_x, target_y, target_z,
                output ready);
endinterface

interface rri_out_if
  import rri_pkg::*;
  #(parameter int CW = 16) ();
  logic          valid;
  logic          ready;
  rri_status_t   status;
  logic signed [CW-1:0] hit_x;
  logic signed [CW-1:0] hit_y;
  logic signed [CW-1:0] hit_z;

  modport source (output valid, status, hit_x, hit_y, hit_z, input ready);
  modport sink (input valid, status, hit_x, hit_y, hit_z, output ready);
endinterface

interface rri_cfg_if
  import rri_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/rri_div_lane.sv @@
module rri_div_lane #(
  parameter int YW  = 73,
  parameter int DDW = 54,
  parameter int QB  = 19
) (
  input  logic           clk,
  input  logic           en,
  input  logic [YW-1:0]  u,
  input  logic [DDW-1:0] dd,
  input  logic           neg_in,
  output logic [QB-1:0]  q,
  output logic           neg_out
);

  localparam int XW = (YW > DDW + QB) ? YW : DDW + QB;

  logic [XW-1:0]  rem_r [QB-1];
  logic [DDW-1:0] dd_r  [QB-1];
  logic [QB-1:0]  q_r   [QB];
  logic           neg_r [QB];

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [XW-1:0]  rem_in;
    logic [DDW-1:0] dd_in;
    logic [QB-1:0]  q_in;
    logic           neg_in_k;
    logic [XW-1:0]  shifted;
    logic           ge;
    logic [QB-1:0]  q_nxt;

    if (k == 0) begin : g_first
      assign rem_in   = XW'(u);
      assign dd_in    = dd;
      assign q_in     = '0;
      assign neg_in_k = neg_in;
    end else begin : g_next
      assign rem_in   = rem_r[k-1];
      assign dd_in    = dd_r[k-1];
      assign q_in     = q_r[k-1];
      assign neg_in_k = neg_r[k-1];
    end

    always_comb begin
      shifted = XW'(dd_in) << (QB - 1 - k);
      ge      = rem_in >= shifted;
      q_nxt   = q_in;
      q_nxt[QB-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]   <= q_nxt;
        neg_r[k] <= neg_in_k;
      end
    end

    if (k < QB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? rem_in - shifted : rem_in;
          dd_r[k]  <= dd_in;
        end
      end
    end
  end

  assign q       = q_r[QB-1];
  assign neg_out = neg_r[QB-1];

endmodule

@@ rtl/core/ray_rectangle_intersection.sv @@
// From an accepted request to its result: six arithmetic stages, COORD_WIDTH + 3
// divider stages, one output register. Throughput: one ray per cycle unless the output stalls;
// the divider is a restoring array, one quotient bit a stage.
// A stalled result freezes the whole pipeline, nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits and the configuration registers.
// A corner write takes effect once the edge registers and then the normal registers have settled.
module ray_rectangle_intersection
  import rri_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input logic      clk,
  input logic      rst_n,
  rri_in_if.sink   in_ch,
  rri_out_if.source out_ch,
  rri_cfg_if.sink  cfg_ch
);

  localparam int CW   = COORD_WIDTH;
  localparam int EW   = CW + 1;
  localparam int NW   = 2 * EW + 1;
  localparam int DW   = NW + EW + 2;
  localparam int PW   = DW + EW;
  localparam int YW   = PW + 2;
  localparam int QB   = CW + 3;
  localparam int HW   = QB + 2;
  localparam int PKW  = 3 * CW;
  localparam int CMPW = ((DW > LIMIT_W) ? DW : LIMIT_W) + 1;
  localparam int NST  = 6 + QB;

  // Configuration.
  logic [CORNER_W-1:0] corner_a_r, corner_b_r, corner_d_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic                cfg_wr;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_a_r <= '0;
      corner_b_r <= '0;
      corner_d_r <= '0;
      limit_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_ch.index)
        REG_CORNER_A:       corner_a_r <= cfg_ch.data;
        REG_CORNER_B:       corner_b_r <= cfg_ch.data;
        REG_CORNER_D:       corner_d_r <= cfg_ch.data;
        REG_PARALLEL_LIMIT: limit_r    <= cfg_ch.data[LIMIT_W-1:0];
        default:            ;
      endcase
    end
  end

  logic [PKW-1:0] a_pk, b_pk, d_pk;
  if (PKW > CORNER_W) begin : g_pk_wide
    assign a_pk = {{(PKW-CORNER_W){1'b0}}, corner_a_r};
    assign b_pk = {{(PKW-CORNER_W){1'b0}}, corner_b_r};
    assign d_pk = {{(PKW-CORNER_W){1'b0}}, corner_d_r};
  end else begin : g_pk_narrow
    assign a_pk = corner_a_r[PKW-1:0];
    assign b_pk = corner_b_r[PKW-1:0];
    assign d_pk = corner_d_r[PKW-1:0];
  end

  logic signed [CW-1:0] a_c [3];
  logic signed [CW-1:0] b_c [3];
  logic signed [CW-1:0] d_c [3];
  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign a_c[i] = a_pk[i*CW +: CW];
    assign b_c[i] = b_pk[i*CW +: CW];
    assign d_c[i] = d_pk[i*CW +: CW];
  end

  // Edges and normal depend on configuration only, so they are kept in registers.
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [NW-1:0] n_r  [3];
  logic                 deg_c;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e1_r[i] <= EW'(b_c[i]) - EW'(a_c[i]);
      e2_r[i] <= EW'(d_c[i]) - EW'(a_c[i]);
    end
    n_r[0] <= NW'(e1_r[1] * e2_r[2]) - NW'(e1_r[2] * e2_r[1]);
    n_r[1] <= NW'(e1_r[2] * e2_r[0]) - NW'(e1_r[0] * e2_r[2]);
    n_r[2] <= NW'(e1_r[0] * e2_r[1]) - NW'(e1_r[1] * e2_r[0]);
  end

  assign deg_c = (n_r[0] == '0) && (n_r[1] == '0) && (n_r[2] == '0);

  // Pipeline control.
  logic           en;
  logic           in_acc;
  logic [NST-1:0] vld_r;
  logic           out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NST-2:0], in_acc};
      out_valid_r <= vld_r[NST-1];
    end
  end

  // Stage 1: direction and origin relative to corner A.
  logic signed [CW-1:0] o_in [3];
  logic signed [CW-1:0] t_in [3];
  logic signed [CW-1:0] o1_r [3];
  logic signed [EW-1:0] d1_r [3];
  logic signed [EW-1:0] w1_r [3];

  assign o_in[0] = in_ch.origin_x;
  assign o_in[1] = in_ch.origin_y;
  assign o_in[2] = in_ch.origin_z;
  assign t_in[0] = in_ch.target_x;
  assign t_in[1] = in_ch.target_y;
  assign t_in[2] = in_ch.target_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        o1_r[i] <= o_in[i];
        d1_r[i] <= EW'(t_in[i]) - EW'(o_in[i]);
        w1_r[i] <= EW'(o_in[i]) - EW'(a_c[i]);
      end
    end
  end

  // Stage 2: denominator, t numerator and the two cross products.
  logic signed [CW-1:0] o2_r [3];
  logic signed [EW-1:0] d2_r [3];
  logic signed [DW-1:0] den2_r, num2_r;
  logic signed [NW-1:0] c1_2_r [3];
  logic signed [NW-1:0] c2_2_r [3];
  logic signed [DW-1:0] den2_c, nw2_c;

  always_comb begin
    den2_c = DW'(n_r[0] * d1_r[0]) + DW'(n_r[1] * d1_r[1]) + DW'(n_r[2] * d1_r[2]);
    nw2_c  = DW'(n_r[0] * w1_r[0]) + DW'(n_r[1] * w1_r[1]) + DW'(n_r[2] * w1_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o2_r   <= o1_r;
      d2_r   <= d1_r;
      den2_r <= den2_c;
      num2_r <= -nw2_c;
      c1_2_r[0] <= NW'(w1_r[1] * e2_r[2]) - NW'(w1_r[2] * e2_r[1]);
      c1_2_r[1] <= NW'(w1_r[2] * e2_r[0]) - NW'(w1_r[0] * e2_r[2]);
      c1_2_r[2] <= NW'(w1_r[0] * e2_r[1]) - NW'(w1_r[1] * e2_r[0]);
      c2_2_r[0] <= NW'(e1_r[1] * w1_r[2]) - NW'(e1_r[2] * w1_r[1]);
      c2_2_r[1] <= NW'(e1_r[2] * w1_r[0]) - NW'(e1_r[0] * w1_r[2]);
      c2_2_r[2] <= NW'(e1_r[0] * w1_r[1]) - NW'(e1_r[1] * w1_r[0]);
    end
  end

  // Stage 3: in-plane numerators and the early exits.
  logic signed [CW-1:0] o3_r [3];
  logic signed [EW-1:0] d3_r [3];
  logic signed [DW-1:0] den3_r, num3_r, sn3_r, rn3_r;
  rri_status_t          st3_r, st3_c;
  logic [DW-1:0]        absden;

  always_comb begin
    absden = den2_r[DW-1] ? DW'(-den2_r) : DW'(den2_r);
    if (deg_c) begin
      st3_c = ST_OUTSIDE;
    end else if ((den2_r == '0) || (CMPW'(absden) < CMPW'(limit_r))) begin
      st3_c = ST_PARALLEL;
    end else if ((num2_r != '0) && (num2_r[DW-1] != den2_r[DW-1])) begin
      st3_c = ST_BEHIND;
    end else begin
      // Still a candidate; the in-plane range test comes later.
      st3_c = ST_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o3_r   <= o2_r;
      d3_r   <= d2_r;
      den3_r <= den2_r;
      num3_r <= num2_r;
      sn3_r  <= DW'(d2_r[0] * c1_2_r[0]) + DW'(d2_r[1] * c1_2_r[1]) + DW'(d2_r[2] * c1_2_r[2]);
      rn3_r  <= DW'(d2_r[0] * c2_2_r[0]) + DW'(d2_r[1] * c2_2_r[1]) + DW'(d2_r[2] * c2_2_r[2]);
      st3_r  <= st3_c;
    end
  end

  // Stage 4: make the denominator positive.
  logic signed [CW-1:0] o4_r [3];
  logic signed [EW-1:0] d4_r [3];
  logic signed [DW-1:0] den4_r, num4_r, sn4_r, rn4_r;
  rri_status_t          st4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      o4_r  <= o3_r;
      d4_r  <= d3_r;
      st4_r <= st3_r;
      if (den3_r[DW-1]) begin
        den4_r <= -den3_r;
        num4_r <= -num3_r;
        sn4_r  <= -sn3_r;
        rn4_r  <= -rn3_r;
      end else begin
        den4_r <= den3_r;
        num4_r <= num3_r;
        sn4_r  <= sn3_r;
        rn4_r  <= rn3_r;
      end
    end
  end

  // Stage 5: range test on s and r, scaled offsets t*d.
  logic signed [CW-1:0] o5_r [3];
  logic signed [DW-1:0] den5_r;
  logic signed [PW-1:0] prod5_r [3];
  rri_status_t          st5_r;
  logic                 outside4;

  assign outside4 = sn4_r[DW-1] || (den4_r < sn4_r) || rn4_r[DW-1] || (den4_r < rn4_r);

  always_ff @(posedge clk) begin
    if (en) begin
      o5_r   <= o4_r;
      den5_r <= den4_r;
      st5_r  <= ((st4_r == ST_HIT) && outside4) ? ST_OUTSIDE : st4_r;
      for (int i = 0; i < 3; i++) begin
        prod5_r[i] <= PW'(num4_r * d4_r[i]);
      end
    end
  end

  // Stage 6: round-to-nearest dividend 2p + den over 2den, folded to a magnitude.
  logic signed [CW-1:0] o6_r [3];
  rri_status_t          st6_r;
  logic [DW-1:0]        dd6_r;
  logic [YW-1:0]        u6_r [3];
  logic                 neg6_r [3];
  logic [DW-1:0]        dd_c;

  assign dd_c = {den5_r[DW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      o6_r  <= o5_r;
      st6_r <= st5_r;
      dd6_r <= dd_c;
      for (int i = 0; i < 3; i++) begin
        logic signed [YW-1:0] y;
        y = (YW'(prod5_r[i]) <<< 1) + YW'(den5_r);
        neg6_r[i] <= y[YW-1];
        // Floor division of a negative value: ceil of the magnitude.
        u6_r[i] <= y[YW-1] ? ($unsigned(-y) + YW'(dd_c) - YW'(1)) : $unsigned(y);
      end
    end
  end

  // Divider lanes, with the remaining payload carried alongside.
  logic [QB-1:0]        q_l   [3];
  logic                 neg_l [3];
  logic signed [CW-1:0] o_sh_r  [QB][3];
  rri_status_t          st_sh_r [QB];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    rri_div_lane #(.YW(YW), .DDW(DW), .QB(QB)) u_div (
      .clk    (clk),
      .en     (en),
      .u      (u6_r[i]),
      .dd     (dd6_r),
      .neg_in (neg6_r[i]),
      .q      (q_l[i]),
      .neg_out(neg_l[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_sh_r[0]  <= o6_r;
      st_sh_r[0] <= st6_r;
      for (int k = 1; k < QB; k++) begin
        o_sh_r[k]  <= o_sh_r[k-1];
        st_sh_r[k] <= st_sh_r[k-1];
      end
    end
  end

  // Output stage: add back the origin and saturate.
  rri_status_t          st_out_r;
  logic signed [CW-1:0] hit_r [3];
  logic signed [CW-1:0] hit_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [QB:0]   qs;
      logic signed [HW-1:0] h;
      qs = neg_l[i] ? -$signed({1'b0, q_l[i]}) : $signed({1'b0, q_l[i]});
      h  = HW'(o_sh_r[QB-1][i]) + HW'(qs);
      if (st_sh_r[QB-1] != ST_HIT) begin
        hit_c[i] = '0;
      end else if ((h[HW-1:CW-1] != '0) && (h[HW-1:CW-1] != '1)) begin
        hit_c[i] = h[HW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        hit_c[i] = h[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_out_r <= st_sh_r[QB-1];
      hit_r    <= hit_c;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = st_out_r;
  assign out_ch.hit_x  = hit_r[0];
  assign out_ch.hit_y  = hit_r[1];
  assign out_ch.hit_z  = hit_r[2];

  a_zero_unless_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (st_out_r != ST_HIT)) |->
      ((hit_r[0] == '0) && (hit_r[1] == '0) && (hit_r[2] == '0)))
    else $error("hit coordinates nonzero on a miss");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (!en) |=> $stable(vld_r))
    else $error("pipeline moved while output stalled");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[NST-1]) |=> out_valid_r)
    else $error("item lost at the output register");

  a_reset_clears: assert property (@(posedge clk)
    (!rst_n) |=> (!out_valid_r && (vld_r == '0)))
    else $error("valid bits survive reset");

endmodule

@@ tb/sv/ray_rectangle_intersection_tb.sv @@
`timescale 1ns / 1ps

module ray_rectangle_intersection_tb;
  import rri_pkg::*;

  localparam int CW = 16;
  localparam int SETTLE_CYCLES = CW + 16;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic signed [CW-1:0] ox, oy, oz, tx, ty, tz;
  } ray_t;

  typedef struct packed {
    rri_status_t status;
    logic signed [CW-1:0] hx, hy, hz;
  } hit_info_t;

  typedef struct {
    ray_t ray;
    bit known;
    hit_info_t res;
  } ray_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rri_in_if #(.CW(CW)) in_if ();
  rri_out_if #(.CW(CW)) out_if ();
  rri_cfg_if cfg_if ();

  ray_rectangle_intersection #(.COORD_WIDTH(CW)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if), .cfg_ch(cfg_if)
  );

  always #10 clk = ~clk;

  logic [CORNER_W-1:0] corner_a_q, corner_b_q, corner_d_q;
  logic [LIMIT_W-1:0] limit_q;

  hit_info_t pending_hits[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int status_count[4];
  bit no_idle = 1'b0;
  int hold_request = 0;
  int quiet_cycles = 0;

  function automatic longint coord_of(logic [CORNER_W-1:0] corner, int i);
    logic signed [CW-1:0] c;
    c = corner[i*CW +: CW];
    return longint'(c);
  endfunction

  function automatic logic signed [CW-1:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[CW-1:0];
  endfunction

  // Exact integer form of the intersection: every dot product fits in 64 bits,
  // only the scaled hit offset needs a wider intermediate.
  function automatic hit_info_t predict_hit(ray_t r);
    hit_info_t res;
    longint o[3], a[3], e1[3], e2[3], d[3], w[3], n[3], c1[3], c2[3];
    longint den, num, sn, rn, absden;
    logic signed [127:0] prod, y, dd, q, h;
    res.status = ST_HIT;
    res.hx = '0;
    res.hy = '0;
    res.hz = '0;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = longint'(r.tx) - o[0];
    d[1] = longint'(r.ty) - o[1];
    d[2] = longint'(r.tz) - o[2];
    for (int i = 0; i < 3; i++) begin
      a[i] = coord_of(corner_a_q, i);
      e1[i] = coord_of(corner_b_q, i) - a[i];
      e2[i] = coord_of(corner_d_q, i) - a[i];
      w[i] = o[i] - a[i];
    end
    n[0] = e1[1]*e2[2] - e1[2]*e2[1];
    n[1] = e1[2]*e2[0] - e1[0]*e2[2];
    n[2] = e1[0]*e2[1] - e1[1]*e2[0];
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
      res.status = ST_OUTSIDE;
      return res;
    end
    den = n[0]*d[0] + n[1]*d[1] + n[2]*d[2];
    num = -(n[0]*w[0] + n[1]*w[1] + n[2]*w[2]);
    absden = den < 0 ? -den : den;
    if (den == 0 || absden < longint'(limit_q)) begin
      res.status = ST_PARALLEL;
      return res;
    end
    if (num != 0 && ((num < 0) != (den < 0))) begin
      res.status = ST_BEHIND;
      return res;
    end
    c1[0] = w[1]*e2[2] - w[2]*e2[1];
    c1[1] = w[2]*e2[0] - w[0]*e2[2];
    c1[2] = w[0]*e2[1] - w[1]*e2[0];
    c2[0] = e1[1]*w[2] - e1[2]*w[1];
    c2[1] = e1[2]*w[0] - e1[0]*w[2];
    c2[2] = e1[0]*w[1] - e1[1]*w[0];
    sn = d[0]*c1[0] + d[1]*c1[1] + d[2]*c1[2];
    rn = d[0]*c2[0] + d[1]*c2[1] + d[2]*c2[2];
    if (den < 0) begin
      den = -den; num = -num; sn = -sn; rn = -rn;
    end
    if (sn < 0 || sn > den || rn < 0 || rn > den) begin
      res.status = ST_OUTSIDE;
      return res;
    end
    for (int i = 0; i < 3; i++) begin
      prod = 128'(num) * 128'(d[i]);
      // Round to nearest with ties upward: floor((2x + den) / (2 den)).
      y = 2*prod + 128'(den);
      dd = 2*128'(den);
      q = y / dd;
      if (y < 0 && q*dd != y) q = q - 1;
      h = 128'(o[i]) + q;
      if (h > 32767) h = 32767;
      if (h < -32768) h = -32768;
      if (i == 0) res.hx = h[CW-1:0];
      else if (i == 1) res.hy = h[CW-1:0];
      else res.hz = h[CW-1:0];
    end
    return res;
  endfunction

  // Result side: random stalls, plus a long hold when the stimulus asks for one.
  int rx_wait = 0;
  always @(negedge clk) begin
    if (hold_request > 0) begin
      out_if.ready <= 1'b0;
      hold_request <= hold_request - 1;
    end else if (rx_wait > 0) begin
      out_if.ready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    hit_info_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_hits.size() == 0) begin
        $error("result with no request outstanding: status %0d", out_if.status);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        n_checked++;
        status_count[want.status]++;
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          errors++;
        end
        if (out_if.hit_x !== want.hx) begin
          $error("hit_x: expected %0d, got %0d", want.hx, out_if.hit_x);
          errors++;
        end
        if (out_if.hit_y !== want.hy) begin
          $error("hit_y: expected %0d, got %0d", want.hy, out_if.hit_y);
          errors++;
        end
        if (out_if.hit_z !== want.hz) begin
          $error("hit_z: expected %0d, got %0d", want.hz, out_if.hit_z);
          errors++;
        end
      end
      rx_wait = no_idle ? 0 : $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("ray_rectangle_intersection_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_ray(ray_row_t row);
    int gap;
    hit_info_t want;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.origin_x <= row.ray.ox;
    in_if.origin_y <= row.ray.oy;
    in_if.origin_z <= row.ray.oz;
    in_if.target_x <= row.ray.tx;
    in_if.target_y <= row.ray.ty;
    in_if.target_z <= row.ray.tz;
    do @(posedge clk); while (!in_if.ready);
    want = predict_hit(row.ray);
    if (row.known && want != row.res) begin
      $error("predictor disagrees with table row %0d", n_sent);
      errors++;
    end
    pending_hits.insert(pending_hits.size(), row.known ? row.res : want);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_CORNER_A: corner_a_q = value;
      REG_CORNER_B: corner_b_q = value;
      REG_CORNER_D: corner_d_q = value;
      REG_PARALLEL_LIMIT: limit_q = value[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [CORNER_W-1:0] pack(longint x, longint y, longint z);
    return {clamp16(z), clamp16(y), clamp16(x)};
  endfunction

  task automatic set_shape(logic [CORNER_W-1:0] a, logic [CORNER_W-1:0] b,
                           logic [CORNER_W-1:0] d, logic [CFG_DATA_W-1:0] lim);
    drain();
    write_reg(REG_CORNER_A, a);
    write_reg(REG_CORNER_B, b);
    write_reg(REG_CORNER_D, d);
    write_reg(REG_PARALLEL_LIMIT, lim);
  endtask

  function automatic ray_row_t make_row(longint ox, longint oy, longint oz,
                                        longint tx, longint ty, longint tz);
    ray_row_t row;
    row.ray.ox = clamp16(ox); row.ray.oy = clamp16(oy); row.ray.oz = clamp16(oz);
    row.ray.tx = clamp16(tx); row.ray.ty = clamp16(ty); row.ray.tz = clamp16(tz);
    row.known = 1'b0;
    row.res = '{ST_HIT, '0, '0, '0};
    return row;
  endfunction

  function automatic ray_row_t with_result(ray_row_t row, rri_status_t st,
                                           longint hx, longint hy, longint hz);
    row.known = 1'b1;
    row.res = '{st, clamp16(hx), clamp16(hy), clamp16(hz)};
    return row;
  endfunction

  // Aims a ray at a random point of the current parallelogram, with a few
  // points pushed just past an edge.
  function automatic ray_row_t aimed_ray(int spread);
    longint p[3], o[3], t[3], s, r;
    s = longint'($urandom_range(0, 300)) - 22;
    r = longint'($urandom_range(0, 300)) - 22;
    for (int i = 0; i < 3; i++) begin
      p[i] = coord_of(corner_a_q, i) +
             ((coord_of(corner_b_q, i) - coord_of(corner_a_q, i)) * s +
              (coord_of(corner_d_q, i) - coord_of(corner_a_q, i)) * r) / 256;
      o[i] = p[i] + longint'($urandom_range(0, 2*spread)) - spread;
      t[i] = $urandom_range(0, 3) == 0 ? p[i] + (p[i] - o[i]) : p[i];
    end
    return make_row(o[0], o[1], o[2], t[0], t[1], t[2]);
  endfunction

  function automatic ray_row_t noise_ray();
    ray_row_t row;
    row = make_row(0, 0, 0, 0, 0, 0);
    {row.ray.ox, row.ray.oy, row.ray.oz} = 48'({$urandom, $urandom});
    {row.ray.tx, row.ray.ty, row.ray.tz} = 48'({$urandom, $urandom});
    return row;
  endfunction

  function automatic logic [CORNER_W-1:0] rand_corner(int span);
    return pack(longint'($urandom_range(0, 2*span)) - span,
                longint'($urandom_range(0, 2*span)) - span,
                longint'($urandom_range(0, 2*span)) - span);
  endfunction

  ray_row_t directed[$];

  function automatic void add_row(ray_row_t row);
    directed.insert(directed.size(), row);
  endfunction

  initial begin
    in_if.valid = 1'b0;
    in_if.origin_x = '0; in_if.origin_y = '0; in_if.origin_z = '0;
    in_if.target_x = '0; in_if.target_y = '0; in_if.target_z = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_CORNER_A;
    cfg_if.data = '0;
    corner_a_q = '0; corner_b_q = '0; corner_d_q = '0; limit_q = '0;
    foreach (status_count[i]) status_count[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // All corners are zero after reset, so the shape is degenerate.
    send_ray(with_result(make_row(0, 0, 256, 0, 0, 0), ST_OUTSIDE, 0, 0, 0));
    send_ray(with_result(make_row(-32768, -32768, -32768, 32767, 32767, 32767),
                         ST_OUTSIDE, 0, 0, 0));

    // Unit square in the z = 0 plane.
    set_shape(pack(0, 0, 0), pack(256, 0, 0), pack(0, 256, 0), 0);
    add_row(with_result(make_row(128, 128, 256, 128, 128, 0), ST_HIT, 128, 128, 0));
    add_row(with_result(make_row(0, 0, 256, 0, 0, 0), ST_HIT, 0, 0, 0));
    add_row(with_result(make_row(256, 256, 512, 256, 256, 256), ST_HIT, 256, 256, 0));
    // Origin on the plane counts as a hit at the origin.
    add_row(with_result(make_row(64, 64, 0, 64, 64, 256), ST_HIT, 64, 64, 0));
    // Direction along the plane: zero denominator even with a zero limit.
    add_row(with_result(make_row(0, 0, 256, 256, 0, 256), ST_PARALLEL, 0, 0, 0));
    add_row(with_result(make_row(5, 5, 5, 5, 5, 5), ST_PARALLEL, 0, 0, 0));
    add_row(with_result(make_row(128, 128, 256, 128, 128, 512), ST_BEHIND, 0, 0, 0));
    add_row(with_result(make_row(1000, 128, 256, 1000, 128, 0), ST_OUTSIDE, 0, 0, 0));
    add_row(with_result(make_row(257, 128, 256, 257, 128, 0), ST_OUTSIDE, 0, 0, 0));
    add_row(make_row(-32768, -32768, 32767, 32767, 32767, -32768));
    add_row(make_row(32767, 32767, 32767, -32768, -32768, -32768));
    add_row(make_row(-32768, 0, 1, 32767, 0, 0));
    add_row(make_row(1, 1, 32767, 2, 2, 32766));
    add_row(make_row(0, 0, -32768, 32767, -32768, 32767));
    foreach (directed[i]) send_ray(directed[i]);

    // Every ray with a small denominator is parallel at the largest limit.
    set_shape(pack(0, 0, 0), pack(256, 0, 0), pack(0, 256, 0), {CFG_DATA_W{1'b1}});
    send_ray(with_result(make_row(128, 128, 256, 128, 128, 0), ST_PARALLEL, 0, 0, 0));
    send_ray(make_row(0, 0, 32767, 0, 0, -32768));

    // Extreme corners: edges spanning the full coordinate range give a very large normal.
    set_shape(pack(-32768, -32768, 0), pack(32767, -32768, 0), pack(-32768, 32767, 32767), 1);
    for (int i = 0; i < 8; i++) send_ray(noise_ray());
    for (int i = 0; i < 8; i++) send_ray(aimed_ray(20000));

    for (int ph = 0; ph < 10; ph++) begin
      int span;
      span = (ph % 3 == 0) ? 32767 : 2000;
      set_shape(rand_corner(span), rand_corner(span), rand_corner(span),
                (ph % 2) ? 48'($urandom_range(0, 4096)) : 48'({$urandom, $urandom}));
      no_idle = (ph % 4 == 1);
      for (int i = 0; i < 85; i++) begin
        if (ph == 2 && i == 10) begin
          // Back the pipeline up: results held while requests keep coming.
          no_idle = 1'b1;
          hold_request = 300;
        end
        if (ph == 2 && i == 60) no_idle = 1'b0;
        if (ph == 5 && i == 40) drain();
        if ($urandom_range(0, 4) == 0) send_ray(noise_ray());
        else send_ray(aimed_ray($urandom_range(0, 1) ? 3000 : 300));
      end
      if (ph == 3) set_shape(pack(0, 0, 0), pack(512, 0, 0), pack(1024, 0, 0), 0);
      if (ph == 3) for (int i = 0; i < 6; i++) send_ray(noise_ray());
    end

    in_if.valid <= 1'b0;
    no_idle = 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("%0d rays sent, %0d results checked across reset, directed and 14 shapes",
             n_sent, n_checked);
    $display("status mix: hit %0d, parallel %0d, behind %0d, outside %0d",
             status_count[0], status_count[1], status_count[2], status_count[3]);
    if (errors == 0) begin
      $display("ray_rectangle_intersection_tb: clean");
    end else begin
      $display("ray_rectangle_intersection_tb: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/rri_pkg.sv
rtl/core/rri_if.sv
rtl/core/rri_div_lane.sv
rtl/core/ray_rectangle_intersection.sv
tb/sv/ray_rectangle_intersection_tb.sv
